// ----- hdl/relative_uri_splitter_unescaper_defines.svh -----
// Assertion macros used by the URI splitter top level.
`ifndef RELATIVE_URI_SPLITTER_UNESCAPER_DEFINES_SVH
`define RELATIVE_URI_SPLITTER_UNESCAPER_DEFINES_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define RUSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition is never true at a rising clock edge outside reset.
`define RUSU_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/rusu_pkg.sv -----
// Package with the types, codes and character helpers of the URI splitter.
`default_nettype none

package rusu_pkg;

	// Result event codes.
	localparam logic [1:0] EV_BYTE  = 2'd0;
	localparam logic [1:0] EV_PARAM = 2'd1;
	localparam logic [1:0] EV_DONE  = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	// Section codes.
	localparam logic [1:0] SEC_PATH  = 2'd0;
	localparam logic [1:0] SEC_NAME  = 2'd1;
	localparam logic [1:0] SEC_VALUE = 2'd2;
	localparam logic [1:0] SEC_FRAG  = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_SYMBOL     = 2'd1;
	localparam logic [1:0] ERR_INCOMPLETE = 2'd2;
	localparam logic [1:0] ERR_HEX        = 2'd3;

	// Escape phases.
	localparam logic [1:0] ESC_NONE    = 2'd0;
	localparam logic [1:0] ESC_FIRST   = 2'd1;
	localparam logic [1:0] ESC_SECOND  = 2'd2;
	localparam logic [1:0] ESC_BAD_HI  = 2'd3;

	// Parameter phases.
	localparam logic [1:0] PP_START   = 2'd0;
	localparam logic [1:0] PP_NAMED   = 2'd1;
	localparam logic [1:0] PP_VALUE   = 2'd2;
	localparam logic [1:0] PP_DROPPED = 2'd3;

	// Characters with a special meaning.
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Most results one input byte can cause.
	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_uri;
	} in_req_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [1:0] section;
		logic [7:0] out_byte;
		logic [1:0] error_code;
		logic       last;
	} result_t;

	// All results of one input byte, in order, with their count.
	typedef struct packed {
		result_t [MAX_RES-1:0] res;
		logic [1:0]            cnt;
	} bundle_t;

	// Returns {valid, value} for a hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic plain_ok(input logic [7:0] c, input logic [1:0] sec,
		input logic slash_frag);
		logic ok;
		ok = (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h2D, 8'h5F, 8'h2E, 8'h7E});
		if (c == CH_SLASH && (sec == SEC_PATH || (sec == SEC_FRAG && slash_frag))) begin
			ok = 1'b1;
		end
		return ok;
	endfunction

	function automatic logic is_delim(input logic [7:0] c, input logic [1:0] sec);
		logic d;
		case (sec)
			SEC_PATH:  d = (c == CH_QMARK) || (c == CH_HASH);
			SEC_NAME:  d = (c == CH_EQUAL) || (c == CH_AMP) || (c == CH_HASH);
			SEC_VALUE: d = (c == CH_AMP) || (c == CH_HASH);
			default:   d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/rusu_parse.sv -----
// Parser state and the single-pass step that turns one byte into its results.
`default_nettype none

module rusu_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rusu_pkg::in_req_t req,
	input  wire logic              accept,
	input  wire logic              slash_frag,
	output rusu_pkg::bundle_t      bundle
);

	logic [1:0] sec_q, esc_q, pp_q;
	logic [3:0] hi_q;
	logic       err_seen_q;

	logic [1:0] sec_d, esc_d, pp_d;
	logic [3:0] hi_d;
	logic       err_seen_d;

	logic [7:0] c;
	logic       eou;
	logic       b_en, p_mid, p_end;
	logic [7:0] b_val;
	logic [1:0] err;
	logic [4:0] hx;

	assign c   = req.in_byte;
	assign eou = req.end_of_uri;
	assign hx  = rusu_pkg::hex_digit(c);

	always_comb begin
		sec_d      = sec_q;
		esc_d      = esc_q;
		pp_d       = pp_q;
		hi_d       = hi_q;
		err_seen_d = err_seen_q;
		b_en       = 1'b0;
		b_val      = 8'd0;
		p_mid      = 1'b0;
		p_end      = 1'b0;
		err        = rusu_pkg::ERR_NONE;

		if (err_seen_q) begin
			// Silent until the byte that closes the URI.
		end else if (esc_q != rusu_pkg::ESC_NONE) begin
			if (rusu_pkg::is_delim(c, sec_q)) begin
				err = rusu_pkg::ERR_INCOMPLETE;
			end else if (esc_q == rusu_pkg::ESC_FIRST) begin
				if (eou) begin
					err = rusu_pkg::ERR_INCOMPLETE;
				end else begin
					hi_d  = hx[4] ? hx[3:0] : 4'd0;
					esc_d = hx[4] ? rusu_pkg::ESC_SECOND : rusu_pkg::ESC_BAD_HI;
				end
			end else if (esc_q == rusu_pkg::ESC_BAD_HI || !hx[4]) begin
				err = rusu_pkg::ERR_HEX;
			end else begin
				b_en  = 1'b1;
				b_val = {hi_q, hx[3:0]};
				esc_d = rusu_pkg::ESC_NONE;
				hi_d  = 4'd0;
			end
		end else if (sec_q == rusu_pkg::SEC_VALUE && pp_q == rusu_pkg::PP_DROPPED) begin
			// Value of a parameter with an empty name: swallowed unchecked.
			if (c == rusu_pkg::CH_AMP) begin
				sec_d = rusu_pkg::SEC_NAME;
				pp_d  = rusu_pkg::PP_START;
			end else if (c == rusu_pkg::CH_HASH) begin
				sec_d = rusu_pkg::SEC_FRAG;
				pp_d  = rusu_pkg::PP_START;
			end
		end else if (sec_q == rusu_pkg::SEC_PATH && c == rusu_pkg::CH_QMARK) begin
			sec_d = rusu_pkg::SEC_NAME;
			pp_d  = rusu_pkg::PP_START;
		end else if (sec_q == rusu_pkg::SEC_PATH && c == rusu_pkg::CH_HASH) begin
			sec_d = rusu_pkg::SEC_FRAG;
		end else if (sec_q == rusu_pkg::SEC_NAME && c == rusu_pkg::CH_EQUAL) begin
			sec_d = rusu_pkg::SEC_VALUE;
			pp_d  = (pp_q == rusu_pkg::PP_NAMED) ? rusu_pkg::PP_VALUE
				: rusu_pkg::PP_DROPPED;
		end else if ((sec_q == rusu_pkg::SEC_NAME || sec_q == rusu_pkg::SEC_VALUE) &&
			(c == rusu_pkg::CH_AMP || c == rusu_pkg::CH_HASH)) begin
			p_mid = (sec_q == rusu_pkg::SEC_NAME && pp_q == rusu_pkg::PP_NAMED) ||
				(sec_q == rusu_pkg::SEC_VALUE && pp_q == rusu_pkg::PP_VALUE);
			sec_d = (c == rusu_pkg::CH_AMP) ? rusu_pkg::SEC_NAME : rusu_pkg::SEC_FRAG;
			pp_d  = rusu_pkg::PP_START;
		end else if (c == rusu_pkg::CH_PERCENT) begin
			if (sec_q == rusu_pkg::SEC_NAME) begin
				pp_d = rusu_pkg::PP_NAMED;
			end
			if (eou) begin
				err = rusu_pkg::ERR_INCOMPLETE;
			end else begin
				esc_d = rusu_pkg::ESC_FIRST;
			end
		end else if (c == rusu_pkg::CH_PLUS &&
			(sec_q == rusu_pkg::SEC_NAME || sec_q == rusu_pkg::SEC_VALUE)) begin
			if (sec_q == rusu_pkg::SEC_NAME) begin
				pp_d = rusu_pkg::PP_NAMED;
			end
			b_en  = 1'b1;
			b_val = rusu_pkg::CH_SPACE;
		end else if (rusu_pkg::plain_ok(c, sec_q, slash_frag)) begin
			if (sec_q == rusu_pkg::SEC_NAME) begin
				pp_d = rusu_pkg::PP_NAMED;
			end
			b_en  = 1'b1;
			b_val = c;
		end else begin
			err = rusu_pkg::ERR_SYMBOL;
		end

		// A parameter still open when the URI closes is completed first.
		if (!err_seen_q && err == rusu_pkg::ERR_NONE && eou) begin
			p_end = (sec_d == rusu_pkg::SEC_NAME && pp_d == rusu_pkg::PP_NAMED) ||
				(sec_d == rusu_pkg::SEC_VALUE && pp_d == rusu_pkg::PP_VALUE);
		end
		if (err != rusu_pkg::ERR_NONE && !eou) begin
			err_seen_d = 1'b1;
		end
		if (eou) begin
			sec_d      = rusu_pkg::SEC_PATH;
			esc_d      = rusu_pkg::ESC_NONE;
			pp_d       = rusu_pkg::PP_START;
			hi_d       = 4'd0;
			err_seen_d = 1'b0;
		end
	end

	// Pack the results in order: byte or parameter end, then error or closing events.
	always_comb begin
		logic [1:0] k;
		logic [1:0] sec_end;
		k       = 2'd0;
		bundle  = '0;
		sec_end = sec_q;
		// The section after the byte's own switch, before the reset at the end.
		if (!err_seen_q) begin
			if (esc_q == rusu_pkg::ESC_NONE) begin
				if (sec_q == rusu_pkg::SEC_VALUE && pp_q == rusu_pkg::PP_DROPPED) begin
					if (c == rusu_pkg::CH_AMP) begin
						sec_end = rusu_pkg::SEC_NAME;
					end else if (c == rusu_pkg::CH_HASH) begin
						sec_end = rusu_pkg::SEC_FRAG;
					end
				end else if (sec_q == rusu_pkg::SEC_PATH && c == rusu_pkg::CH_QMARK) begin
					sec_end = rusu_pkg::SEC_NAME;
				end else if (sec_q == rusu_pkg::SEC_PATH && c == rusu_pkg::CH_HASH) begin
					sec_end = rusu_pkg::SEC_FRAG;
				end else if (sec_q == rusu_pkg::SEC_NAME && c == rusu_pkg::CH_EQUAL) begin
					sec_end = rusu_pkg::SEC_VALUE;
				end else if ((sec_q == rusu_pkg::SEC_NAME || sec_q == rusu_pkg::SEC_VALUE)
					&& (c == rusu_pkg::CH_AMP || c == rusu_pkg::CH_HASH)) begin
					sec_end = (c == rusu_pkg::CH_AMP) ? rusu_pkg::SEC_NAME
						: rusu_pkg::SEC_FRAG;
				end
			end
		end
		if (b_en) begin
			bundle.res[k] = '{rusu_pkg::EV_BYTE, sec_q, b_val, rusu_pkg::ERR_NONE, 1'b0};
			k = k + 2'd1;
		end
		if (p_mid) begin
			bundle.res[k] = '{rusu_pkg::EV_PARAM, sec_q, 8'd0, rusu_pkg::ERR_NONE, 1'b0};
			k = k + 2'd1;
		end
		if (err != rusu_pkg::ERR_NONE) begin
			bundle.res[k] = '{rusu_pkg::EV_ERROR, sec_q, 8'd0, err, 1'b0};
			k = k + 2'd1;
		end else if (eou && !err_seen_q) begin
			if (p_end) begin
				bundle.res[k] = '{rusu_pkg::EV_PARAM, sec_end, 8'd0,
					rusu_pkg::ERR_NONE, 1'b0};
				k = k + 2'd1;
			end
			bundle.res[k] = '{rusu_pkg::EV_DONE, sec_end, 8'd0, rusu_pkg::ERR_NONE, 1'b0};
			k = k + 2'd1;
		end
		if (k != 2'd0) begin
			bundle.res[k - 2'd1].last = 1'b1;
		end
		bundle.cnt = k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q      <= rusu_pkg::SEC_PATH;
			esc_q      <= rusu_pkg::ESC_NONE;
			pp_q       <= rusu_pkg::PP_START;
			hi_q       <= 4'd0;
			err_seen_q <= 1'b0;
		end else if (accept) begin
			sec_q      <= sec_d;
			esc_q      <= esc_d;
			pp_q       <= pp_d;
			hi_q       <= hi_d;
			err_seen_q <= err_seen_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/rusu_outq.sv -----
// Two-entry queue of result bundles that hands out one result per cycle while out_stall is low.
`default_nettype none

module rusu_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rusu_pkg::bundle_t wdata,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rusu_pkg::result_t      out_res
);

	rusu_pkg::bundle_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic [1:0] idx_q;
	logic       pop_res, pop_bundle, do_push;

	assign full       = (count_q == 2'd2);
	assign out_valid  = (count_q != 2'd0);
	assign out_res    = mem_q[rd_ptr_q].res[idx_q];
	assign pop_res    = out_valid && !out_stall;
	assign pop_bundle = pop_res && (idx_q == mem_q[rd_ptr_q].cnt - 2'd1);
	// Bytes that cause no result leave nothing in the queue.
	assign do_push    = push && (wdata.cnt != 2'd0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			idx_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_bundle) begin
				rd_ptr_q <= ~rd_ptr_q;
				idx_q    <= 2'd0;
			end else if (pop_res) begin
				idx_q <= idx_q + 2'd1;
			end
			case ({do_push, pop_bundle})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/relative_uri_splitter_unescaper.sv -----
// Top level of the relative URI splitter and percent-decoder.
`default_nettype none
`include "relative_uri_splitter_unescaper_defines.svh"

// The block takes one URI byte per request and splits the URI into path, query
// parameters (name, then value) and fragment, percent-decoding every byte and
// turning '+' into a space inside the query. Each input request yields zero to
// three result requests: a decoded byte, a parameter-complete event, and an
// error event at the first faulty byte or a done event at the byte flagged
// end_of_uri; the final result of a byte has last set. A byte is accepted every
// cycle as long as each byte yields at most one result and the receiver does not
// stall. Results leave through a single output port one per cycle while
// out_stall is low, from a two-entry queue of per-byte result bundles; in_stall
// rises only when that queue is full, so it never depends combinationally on
// out_stall. With an empty queue, the first result of a byte is offered in the
// cycle after the byte is accepted. After the first error the block stays
// silent until the end of the URI. The fragment_allows_slash register is
// written through cfg_wr_en and should only change while idle.
module relative_uri_splitter_unescaper (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rusu_pkg::in_req_t in_req,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rusu_pkg::result_t      out_res,
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_wr_data
);

	logic              frag_slash_q;
	logic              in_accept;
	logic              q_full;
	rusu_pkg::bundle_t bundle;

	// A byte is taken whenever the result queue has room for its bundle.
	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_slash_q <= 1'b0;
		end else if (cfg_wr_en) begin
			frag_slash_q <= cfg_wr_data;
		end
	end

	// The parser updates its state and produces all results of the byte at once.
	rusu_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (in_req),
		.accept     (in_accept),
		.slash_frag (frag_slash_q),
		.bundle     (bundle)
	);

	// The queue serializes each bundle onto the output, one result per cycle while out_stall is low.
	rusu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.wdata     (bundle),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// Only decoded bytes carry a byte value.
	`RUSU_ASSERT(a_byte_zero, out_valid && out_res.event_res != rusu_pkg::EV_BYTE |-> out_res.out_byte == 8'd0, "non-byte result carries a byte value")
	// An error code appears exactly on error events.
	`RUSU_ASSERT(a_err_code, out_valid |-> ((out_res.event_res == rusu_pkg::EV_ERROR) == (out_res.error_code != rusu_pkg::ERR_NONE)), "error code does not match event")
	// Done and error events close their byte's results.
	`RUSU_ASSERT(a_close_last, out_valid && (out_res.event_res == rusu_pkg::EV_DONE || out_res.event_res == rusu_pkg::EV_ERROR) |-> out_res.last, "closing event not marked last")
	// No byte is accepted into a full result queue.
	`RUSU_NEVER(a_no_overflow, in_accept && q_full, "request accepted into full queue")

endmodule

`default_nettype wire
